[rtl/greedy_portfolio_selector_defines.svh]
// Assertion macros shared by the greedy portfolio selector RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef GREEDY_PORTFOLIO_SELECTOR_DEFINES_SVH
`define GREEDY_PORTFOLIO_SELECTOR_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define GPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define GPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gps_pkg.sv]
// Package for the greedy portfolio selector: field widths, codes, state type
// and the command/status structs between controller and datapath. No dependencies.
package gps_pkg;

    localparam int PSIZE_W = 5;
    localparam int GCNT_W  = 7;
    localparam int CCNT_W  = 12;
    localparam int GIDX_W  = 6;
    localparam int CAND_W  = 11;
    localparam int COST_W  = 32;
    localparam int TOTAL_W = 38;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CCNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PORTFOLIO_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CANDIDATE_COUNT = 2'd2;

    localparam logic [PSIZE_W-1:0] PSIZE_RESET = 5'd1;
    localparam logic [GCNT_W-1:0]  GCNT_RESET  = 7'd1;
    localparam logic [CCNT_W-1:0]  CCNT_RESET  = 12'd1120;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_UPDATE,
        ST_UPD_DRAIN,
        ST_EMIT
    } gps_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic clear;
        logic scan_begin;
        logic scan_issue;
        logic upd_begin;
        logic upd_issue;
        logic emit;
    } gps_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_end;
        logic upd_end;
        logic pipe_busy;
        logic no_picks;
        logic zero_grp;
        logic out_free;
        logic pick_last;
    } gps_sts_t;

endpackage

[rtl/gps_datapath.sv]
// Datapath of the greedy portfolio selector: cost, best and used memories,
// scan counters, min/sum pipeline, winner compare and output register. Uses gps_pkg.
module gps_datapath
    import gps_pkg::*;
#(
    parameter int MAX_GROUPS     = 64,
    parameter int MAX_CANDIDATES = 2048,
    parameter int MAX_PORTFOLIO  = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  gps_cmd_t            cmd,
    output gps_sts_t            sts,
    input  logic [PSIZE_W-1:0]  portfolio_size,
    input  logic [GCNT_W-1:0]   group_count,
    input  logic [CCNT_W-1:0]   candidate_count,
    input  logic [GIDX_W-1:0]   group_index,
    input  logic [CAND_W-1:0]   candidate_index,
    input  logic [COST_W-1:0]   cost_value,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [CAND_W-1:0]   chosen_candidate,
    output logic [TOTAL_W-1:0]  portfolio_total,
    output logic                last_pick
);

    localparam int GIW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CIW   = $clog2(MAX_CANDIDATES);
    localparam int PIW   = (MAX_PORTFOLIO > 1) ? $clog2(MAX_PORTFOLIO) : 1;
    localparam int GCW   = $clog2(MAX_GROUPS + 1);
    localparam int CCW   = $clog2(MAX_CANDIDATES + 1);
    localparam int PCW   = $clog2(MAX_PORTFOLIO + 1);
    localparam int DEPTH = MAX_GROUPS * MAX_CANDIDATES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CLR_N = (MAX_GROUPS > MAX_CANDIDATES) ? MAX_GROUPS : MAX_CANDIDATES;
    localparam int CLW   = $clog2(CLR_N);

    logic [COST_W-1:0] cost_mem [DEPTH];
    logic [COST_W-1:0] best_mem [MAX_GROUPS];
    logic              used_mem [MAX_CANDIDATES];

    logic [COST_W-1:0] cost_rd_reg;
    logic [COST_W-1:0] best_rd_reg;
    logic              used_rd_reg;

    logic [GCW-1:0] grp_eff;
    logic [CCW-1:0] cand_eff;
    logic [PCW-1:0] pick_cap;
    logic [PCW-1:0] pick_eff;

    logic [GIW-1:0] glast_reg;
    logic [CIW-1:0] clast_reg;
    logic [PIW-1:0] plast_reg;
    logic           zero_grp_reg;
    logic           no_picks_reg;

    logic [CLW-1:0] clr_cnt_reg;
    logic [CIW-1:0] c_cnt_reg;
    logic [GIW-1:0] g_cnt_reg;
    logic [AW-1:0]  addr_reg;
    logic [PIW-1:0] pick_cnt_reg;

    logic           ld_ok;
    logic [AW-1:0]  ld_addr;

    logic              best_we;
    logic [GIW-1:0]    best_wa;
    logic [COST_W-1:0] best_wd;
    logic              used_we;
    logic [CIW-1:0]    used_wa;
    logic              used_wd;

    logic           s1_v_reg;
    logic           s1_w_reg;
    logic           s1_first_reg;
    logic           s1_last_reg;
    logic [CIW-1:0] s1_cand_reg;
    logic [GIW-1:0] s1_wg_reg;

    logic              s2_v_reg;
    logic              s2_first_reg;
    logic              s2_last_reg;
    logic              s2_used_reg;
    logic [CIW-1:0]    s2_cand_reg;
    logic [COST_W-1:0] min_reg;

    logic [TOTAL_W-1:0] acc_reg;
    logic [TOTAL_W:0]   sum_wide;
    logic [TOTAL_W-1:0] acc_next;

    logic               s3_v_reg;
    logic               s3_used_reg;
    logic [CIW-1:0]     s3_cand_reg;
    logic [TOTAL_W-1:0] tot_reg;

    logic               have_reg;
    logic               take;
    logic [CIW-1:0]     winner_reg;
    logic [TOTAL_W-1:0] win_total_reg;

    logic               out_valid_reg;
    logic [CAND_W-1:0]  chosen_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               last_reg;

    logic [COST_W-1:0] cur_min;

    // effective sizes at start
    always_comb
    begin
        grp_eff  = (32'(group_count) > 32'(MAX_GROUPS)) ? GCW'(MAX_GROUPS) : GCW'(group_count);
        cand_eff = (32'(candidate_count) > 32'(MAX_CANDIDATES)) ?
                   CCW'(MAX_CANDIDATES) : CCW'(candidate_count);
        pick_cap = (32'(portfolio_size) > 32'(MAX_PORTFOLIO)) ?
                   PCW'(MAX_PORTFOLIO) : PCW'(portfolio_size);
        pick_eff = (32'(pick_cap) > 32'(cand_eff)) ? PCW'(cand_eff) : pick_cap;
    end

    assign ld_ok   = (32'(group_index) < 32'(MAX_GROUPS)) &&
                     (32'(candidate_index) < 32'(MAX_CANDIDATES));
    assign ld_addr = AW'(32'(group_index) * 32'(MAX_CANDIDATES) + 32'(candidate_index));

    assign cur_min = (cost_rd_reg < best_rd_reg) ? cost_rd_reg : best_rd_reg;

    always_comb
    begin
        best_we = 1'b0;
        best_wa = s1_wg_reg;
        best_wd = cur_min;
        if (cmd.clear)
        begin
            best_we = 32'(clr_cnt_reg) < 32'(MAX_GROUPS);
            best_wa = GIW'(clr_cnt_reg);
            best_wd = '1;
        end
        else if (s1_w_reg)
        begin
            best_we = 1'b1;
        end
    end

    always_comb
    begin
        used_we = 1'b0;
        used_wa = winner_reg;
        used_wd = 1'b1;
        if (cmd.clear)
        begin
            used_we = 32'(clr_cnt_reg) < 32'(MAX_CANDIDATES);
            used_wa = CIW'(clr_cnt_reg);
            used_wd = 1'b0;
        end
        else if (cmd.emit)
        begin
            used_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && ld_ok)
        begin
            cost_mem[ld_addr] <= cost_value;
        end
        cost_rd_reg <= cost_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (best_we)
        begin
            best_mem[best_wa] <= best_wd;
        end
        best_rd_reg <= best_mem[g_cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_wa] <= used_wd;
        end
        used_rd_reg <= used_mem[c_cnt_reg];
    end

    // saturating accumulate
    assign sum_wide = {1'b0, acc_reg} + (TOTAL_W + 1)'(min_reg);
    always_comb
    begin
        if (s2_first_reg)
        begin
            acc_next = TOTAL_W'(min_reg);
        end
        else if (sum_wide[TOTAL_W])
        begin
            acc_next = '1;
        end
        else
        begin
            acc_next = sum_wide[TOTAL_W-1:0];
        end
    end

    assign take = s3_v_reg && !s3_used_reg && (!have_reg || (tot_reg < win_total_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glast_reg     <= '0;
            clast_reg     <= '0;
            plast_reg     <= '0;
            zero_grp_reg  <= 1'b0;
            no_picks_reg  <= 1'b0;
            clr_cnt_reg   <= '0;
            c_cnt_reg     <= '0;
            g_cnt_reg     <= '0;
            addr_reg      <= '0;
            pick_cnt_reg  <= '0;
            s1_v_reg      <= 1'b0;
            s1_w_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                zero_grp_reg <= (grp_eff == '0);
                glast_reg    <= (grp_eff == '0) ? '0 : GIW'(grp_eff - 1'b1);
                clast_reg    <= CIW'(cand_eff - 1'b1);
                plast_reg    <= PIW'(pick_eff - 1'b1);
                no_picks_reg <= (pick_eff == '0);
                clr_cnt_reg  <= '0;
                pick_cnt_reg <= '0;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.scan_begin)
            begin
                c_cnt_reg <= '0;
                g_cnt_reg <= '0;
                addr_reg  <= '0;
            end
            else if (cmd.scan_issue)
            begin
                if (g_cnt_reg == glast_reg)
                begin
                    g_cnt_reg <= '0;
                    c_cnt_reg <= c_cnt_reg + 1'b1;
                    addr_reg  <= AW'(32'(c_cnt_reg) + 1);
                end
                else
                begin
                    g_cnt_reg <= g_cnt_reg + 1'b1;
                    addr_reg  <= addr_reg + AW'(MAX_CANDIDATES);
                end
            end
            else if (cmd.upd_begin)
            begin
                g_cnt_reg <= '0;
                addr_reg  <= AW'(winner_reg);
            end
            else if (cmd.upd_issue)
            begin
                g_cnt_reg <= g_cnt_reg + 1'b1;
                addr_reg  <= addr_reg + AW'(MAX_CANDIDATES);
            end
            if (cmd.emit)
            begin
                pick_cnt_reg <= pick_cnt_reg + 1'b1;
            end
            s1_v_reg <= cmd.scan_issue;
            s1_w_reg <= cmd.upd_issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg && s2_last_reg;
            if (cmd.scan_begin)
            begin
                have_reg <= 1'b0;
            end
            else if (take)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (g_cnt_reg == '0);
        s1_last_reg  <= (g_cnt_reg == glast_reg);
        s1_cand_reg  <= c_cnt_reg;
        s1_wg_reg    <= g_cnt_reg;

        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_used_reg  <= used_rd_reg;
        s2_cand_reg  <= s1_cand_reg;
        min_reg      <= zero_grp_reg ? '0 : cur_min;

        if (s2_v_reg)
        begin
            acc_reg <= acc_next;
            if (s2_last_reg)
            begin
                tot_reg     <= acc_next;
                s3_used_reg <= s2_used_reg;
                s3_cand_reg <= s2_cand_reg;
            end
        end

        if (take)
        begin
            winner_reg    <= s3_cand_reg;
            win_total_reg <= tot_reg;
        end

        if (cmd.emit)
        begin
            chosen_reg <= CAND_W'(winner_reg);
            total_reg  <= win_total_reg;
            last_reg   <= (pick_cnt_reg == plast_reg);
        end
    end

    always_comb
    begin
        sts.clear_done = (clr_cnt_reg == CLW'(CLR_N - 1));
        sts.scan_end   = (c_cnt_reg == clast_reg) && (g_cnt_reg == glast_reg);
        sts.upd_end    = (g_cnt_reg == glast_reg);
        sts.pipe_busy  = s1_v_reg || s1_w_reg || s2_v_reg || s3_v_reg;
        sts.no_picks   = no_picks_reg;
        sts.zero_grp   = zero_grp_reg;
        sts.out_free   = !out_valid_reg || !out_stall;
        sts.pick_last  = (pick_cnt_reg == plast_reg);
    end

    assign out_valid        = out_valid_reg;
    assign chosen_candidate = chosen_reg;
    assign portfolio_total  = total_reg;
    assign last_pick        = last_reg;

endmodule

[rtl/gps_ctrl.sv]
// Controller of the greedy portfolio selector: sequences clear, scan, update
// and emit phases. Uses gps_pkg and greedy_portfolio_selector_defines.svh.
`include "greedy_portfolio_selector_defines.svh"

module gps_ctrl
    import gps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     kind,
    output logic     in_stall,
    input  gps_sts_t sts,
    output gps_cmd_t cmd
);

    gps_state_t state_reg;
    gps_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (kind == KIND_START)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                begin
                    if (sts.no_picks)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.scan_begin = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    if (sts.zero_grp)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.upd_begin = 1'b1;
                        state_next    = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                cmd.upd_issue = 1'b1;
                if (sts.upd_end)
                begin
                    state_next = ST_UPD_DRAIN;
                end
            end
            ST_UPD_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.pick_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.scan_begin = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `GPS_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free, "pick emitted into a full output register")
    `GPS_ASSERT_IMP(a_idle_drained, state_reg == ST_IDLE, !sts.pipe_busy, "idle with pipeline busy")
    `GPS_ASSERT_IMP(a_update_groups, state_reg == ST_UPDATE, !sts.zero_grp, "update without groups")
    `GPS_ASSERT_NXT(a_pick_next, cmd.emit && !sts.pick_last, state_reg == ST_SCAN, "next pick lost")

endmodule

[rtl/greedy_portfolio_selector.sv]
// Top level of the greedy portfolio selector: configuration registers and the
// controller/datapath pair. Uses gps_pkg, gps_ctrl and gps_datapath.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  kind, group_index, candidate_index, cost_value
//   out      out_valid/out_stall  chosen_candidate, portfolio_total, last_pick
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A load transfer is accepted while idle; loads may follow back to back.
// A start clears best costs and used marks, then each pick scans the cost memory
// through its single read port and, when groups are in use, updates best costs.
// Intake stalls from start until the last pick is in the output register.
// The output register holds a pick while out_stall is high; the block then waits.
module greedy_portfolio_selector
    import gps_pkg::*;
#(
    parameter int MAX_GROUPS     = 64,
    parameter int MAX_CANDIDATES = 2048,
    parameter int MAX_PORTFOLIO  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   kind,
    input  logic [GIDX_W-1:0]      group_index,
    input  logic [CAND_W-1:0]      candidate_index,
    input  logic [COST_W-1:0]      cost_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CAND_W-1:0]      chosen_candidate,
    output logic [TOTAL_W-1:0]     portfolio_total,
    output logic                   last_pick,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [PSIZE_W-1:0] portfolio_size_reg;
    logic [GCNT_W-1:0]  group_count_reg;
    logic [CCNT_W-1:0]  candidate_count_reg;

    gps_cmd_t cmd;
    gps_sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            portfolio_size_reg  <= PSIZE_RESET;
            group_count_reg     <= GCNT_RESET;
            candidate_count_reg <= CCNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PORTFOLIO_SIZE:  portfolio_size_reg  <= cfg_data[PSIZE_W-1:0];
                CFG_GROUP_COUNT:     group_count_reg     <= cfg_data[GCNT_W-1:0];
                CFG_CANDIDATE_COUNT: candidate_count_reg <= cfg_data[CCNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    gps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gps_datapath #(
        .MAX_GROUPS     (MAX_GROUPS),
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .MAX_PORTFOLIO  (MAX_PORTFOLIO)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .portfolio_size   (portfolio_size_reg),
        .group_count      (group_count_reg),
        .candidate_count  (candidate_count_reg),
        .group_index      (group_index),
        .candidate_index  (candidate_index),
        .cost_value       (cost_value),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .chosen_candidate (chosen_candidate),
        .portfolio_total  (portfolio_total),
        .last_pick        (last_pick)
    );

endmodule
